// ===== src/sbsc_pkg.sv =====
// shared constants, field widths and helpers for the subset bucket support counter
// no dependencies
`timescale 1ns / 1ps

package sbsc_pkg;

  localparam int MASK_W = 6;
  localparam int VAL_W  = 32;
  localparam int LEN_W  = 3;
  localparam int TOT_W  = 6;
  localparam int CNT_W  = 3;

  localparam int MAX_ITEMS_DEF = 6;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_MIN_SUPPORT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_ITEM_COUNT  = 1'b1;

  localparam logic [VAL_W-1:0] MIN_SUPPORT_RST = 32'd1;
  localparam logic [CNT_W-1:0] ITEM_COUNT_RST  = 3'd6;

  function automatic logic [LEN_W-1:0] popcount(input logic [MASK_W-1:0] m);
    logic [LEN_W-1:0] c;
    c = '0;
    for (int b = 0; b < MASK_W; b++) begin
      c = c + LEN_W'(m[b]);
    end
    return c;
  endfunction

endpackage

// ===== src/sbsc_if.sv =====
// request channels: bucket loads in, pattern results out
// depends on sbsc_pkg
`timescale 1ns / 1ps

interface sbsc_in_if;
  logic                        valid;
  logic                        ready;
  logic [sbsc_pkg::MASK_W-1:0] bucket_index;
  logic [sbsc_pkg::VAL_W-1:0]  bucket_value;
  logic                        last_bucket;

  modport source (output valid, bucket_index, bucket_value, last_bucket, input ready);
  modport sink (input valid, bucket_index, bucket_value, last_bucket, output ready);
endinterface

interface sbsc_out_if;
  logic                        valid;
  logic                        ready;
  logic [sbsc_pkg::MASK_W-1:0] subset_mask;
  logic [sbsc_pkg::VAL_W-1:0]  support;
  logic [sbsc_pkg::LEN_W-1:0]  pattern_length;
  logic                        is_summary;
  logic [sbsc_pkg::TOT_W-1:0]  pattern_total;
  logic                        last;

  modport source (output valid, subset_mask, support, pattern_length, is_summary,
                  pattern_total, last, input ready);
  modport sink (input valid, subset_mask, support, pattern_length, is_summary,
                pattern_total, last, output ready);
endinterface

// ===== src/sbsc_store.sv =====
// bucket store: one write port, two registered read ports, per-entry valid bits
// unwritten entries read as zero; depends on sbsc_pkg
`timescale 1ns / 1ps

module sbsc_store #(
  parameter int AW = sbsc_pkg::MASK_W
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       clear,
  input  logic                       we,
  input  logic [AW-1:0]              waddr,
  input  logic [sbsc_pkg::VAL_W-1:0] wdata,
  input  logic [AW-1:0]              raddr_a,
  input  logic [AW-1:0]              raddr_b,
  output logic [sbsc_pkg::VAL_W-1:0] rdata_a,
  output logic [sbsc_pkg::VAL_W-1:0] rdata_b
);

  localparam int DEPTH = 2 ** AW;

  logic [sbsc_pkg::VAL_W-1:0] mem [DEPTH];
  logic [DEPTH-1:0]           valid;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      valid <= '0;
    end else if (we) begin
      valid[waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    rdata_a <= valid[raddr_a] ? mem[raddr_a] : '0;
    rdata_b <= valid[raddr_b] ? mem[raddr_b] : '0;
  end

endmodule

// ===== src/subset_bucket_support_counter.sv =====
// Loads are taken while the block is idle. A last load starts a run over the n
// items in use: one saturating adder walks every bucket pair of each item bit,
// then the scan reads each bucket from mask 1 upward and compares it against
// min_support. No load is taken during a run.
// Reset (synchronous, active high) empties the store through its valid bits and
// sets min_support to 1 and item_count to 6; the store is emptied after every run.
`timescale 1ns / 1ps

module subset_bucket_support_counter #(
  parameter int MAX_ITEMS = sbsc_pkg::MAX_ITEMS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [sbsc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sbsc_pkg::CFG_DATA_W-1:0] cfg_data,
  sbsc_in_if.sink                         bucket_in,
  sbsc_out_if.source                      result_out
);

  localparam int AW = (MAX_ITEMS < sbsc_pkg::MASK_W) ? MAX_ITEMS : sbsc_pkg::MASK_W;
  localparam int IW = $clog2(AW + 1);
  localparam int JW = AW + 1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_XRD,
    ST_XADD,
    ST_SRD,
    ST_SCMP,
    ST_SUM
  } state_t;

  state_t state;

  logic [sbsc_pkg::VAL_W-1:0] min_support;
  logic [sbsc_pkg::CNT_W-1:0] item_count;
  logic [sbsc_pkg::TOT_W-1:0] found_count;
  logic [IW-1:0]              i;
  logic [JW-1:0]              j;

  logic [IW-1:0]              n;
  logic [JW-1:0]              nb;
  logic [AW-1:0]              bit_mask;
  logic [AW-1:0]              j_addr;
  logic                       j_has_bit;
  logic                       out_free;
  logic                       out_load;
  logic                       accept;
  logic                       load_in_range;

  logic                       st_we;
  logic [AW-1:0]              st_waddr;
  logic [sbsc_pkg::VAL_W-1:0] st_wdata;
  logic                       st_clear;
  logic [sbsc_pkg::VAL_W-1:0] rd_a;
  logic [sbsc_pkg::VAL_W-1:0] rd_b;
  logic [sbsc_pkg::VAL_W:0]   sum_wide;
  logic [sbsc_pkg::VAL_W-1:0] sum_sat;
  logic [sbsc_pkg::MASK_W-1:0] scan_mask;

  // items in use, clamped to the store width
  assign n        = (item_count > sbsc_pkg::CNT_W'(AW)) ? IW'(AW) : IW'(item_count);
  assign nb       = JW'(1) << n;
  assign bit_mask = AW'(1) << i;
  assign j_addr   = j[AW-1:0];
  assign j_has_bit = (j_addr & bit_mask) != '0;

  assign out_free      = !result_out.valid || result_out.ready;
  assign out_load      = out_free && (((state == ST_SCMP) && (rd_a >= min_support)) ||
                                      (state == ST_SUM));
  assign bucket_in.ready = (state == ST_IDLE);
  assign accept        = bucket_in.valid && bucket_in.ready;
  assign load_in_range = (bucket_in.bucket_index >> AW) == '0;

  assign sum_wide = {1'b0, rd_a} + {1'b0, rd_b};
  assign sum_sat  = sum_wide[sbsc_pkg::VAL_W] ? '1 : sum_wide[sbsc_pkg::VAL_W-1:0];
  assign scan_mask = sbsc_pkg::MASK_W'(j_addr);

  always_comb begin
    st_we    = 1'b0;
    st_waddr = j_addr;
    st_wdata = sum_sat;
    if (accept) begin
      st_we    = load_in_range;
      st_waddr = AW'(bucket_in.bucket_index);
      st_wdata = bucket_in.bucket_value;
    end else if (state == ST_XADD) begin
      st_we = 1'b1;
    end
  end

  assign st_clear = (state == ST_SUM) && out_free;

  sbsc_store #(
    .AW (AW)
  ) u_store (
    .clk     (clk),
    .rst     (rst),
    .clear   (st_clear),
    .we      (st_we),
    .waddr   (st_waddr),
    .wdata   (st_wdata),
    .raddr_a (j_addr),
    .raddr_b (j_addr | bit_mask),
    .rdata_a (rd_a),
    .rdata_b (rd_b)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= ST_IDLE;
      min_support      <= sbsc_pkg::MIN_SUPPORT_RST;
      item_count       <= sbsc_pkg::ITEM_COUNT_RST;
      found_count      <= '0;
      i                <= '0;
      j                <= '0;
      result_out.valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          sbsc_pkg::REG_MIN_SUPPORT: min_support <= cfg_data[sbsc_pkg::VAL_W-1:0];
          sbsc_pkg::REG_ITEM_COUNT:  item_count  <= cfg_data[sbsc_pkg::CNT_W-1:0];
          default: ;
        endcase
      end

      if (out_load) begin
        result_out.valid <= 1'b1;
      end else if (result_out.valid && result_out.ready) begin
        result_out.valid <= 1'b0;
      end

      case (state)
        ST_IDLE: begin
          if (accept && bucket_in.last_bucket) begin
            i     <= '0;
            j     <= '0;
            state <= ST_XRD;
          end
        end
        ST_XRD: begin
          if (i == n) begin
            j     <= JW'(1);
            state <= ST_SRD;
          end else if (j == nb) begin
            i <= i + IW'(1);
            j <= '0;
          end else if (j_has_bit) begin
            j <= j + JW'(1);
          end else begin
            state <= ST_XADD;
          end
        end
        ST_XADD: begin
          j     <= j + JW'(1);
          state <= ST_XRD;
        end
        ST_SRD: begin
          if (j == nb) begin
            state <= ST_SUM;
          end else begin
            state <= ST_SCMP;
          end
        end
        ST_SCMP: begin
          if (rd_a >= min_support) begin
            if (out_free) begin
              result_out.subset_mask    <= scan_mask;
              result_out.support        <= rd_a;
              result_out.pattern_length <= sbsc_pkg::popcount(scan_mask);
              result_out.is_summary     <= 1'b0;
              result_out.pattern_total  <= '0;
              result_out.last           <= 1'b0;
              found_count               <= found_count + sbsc_pkg::TOT_W'(1);
              j                         <= j + JW'(1);
              state                     <= ST_SRD;
            end
          end else begin
            j     <= j + JW'(1);
            state <= ST_SRD;
          end
        end
        ST_SUM: begin
          if (out_free) begin
            result_out.subset_mask    <= '0;
            result_out.support        <= '0;
            result_out.pattern_length <= '0;
            result_out.is_summary     <= 1'b1;
            result_out.pattern_total  <= found_count;
            result_out.last           <= 1'b1;
            found_count               <= '0;
            state                     <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule
